// File: src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
  localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
  localparam logic [20:0] SUPPLEMENT_BASE  = 21'h010000;
  localparam logic [5:0]  HIGH_SURR_TAG    = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;  // 0xDC00 >> 10

  localparam logic [2:0]  SEQ_NONE  = 3'd0;
  localparam logic [2:0]  SEQ_LEN2  = 3'd2;
  localparam logic [2:0]  SEQ_LEN3  = 3'd3;
  localparam logic [2:0]  SEQ_LEN4  = 3'd4;

  // Open multi-byte sequence
  typedef struct packed {
    logic [2:0]  exp_len;
    logic [2:0]  taken;
    logic [20:0] point;
  } seq_state_t;

  // Code units caused by one input byte, in output order
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } dec_result_t;

endpackage

// File: src/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// Combinational decode of one UTF-8 byte against the open sequence state.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic [7:0]              byte_i,
  input  logic                    eos_i,
  input  logic                    big_endian_i,
  input  u8u16_pkg::seq_state_t   state_i,
  output u8u16_pkg::seq_state_t   state_o,
  output u8u16_pkg::dec_result_t  res_o
);
  import u8u16_pkg::*;

  logic        is_cont;
  logic [2:0]  taken_inc;
  logic [20:0] point_inc;
  logic [20:0] supp_off;
  logic [15:0] raw0;
  logic [15:0] raw1;
  logic [1:0]  cnt;
  logic        as_lead;
  seq_state_t  st;

  assign is_cont   = (byte_i[7:6] == 2'b10);
  assign taken_inc = state_i.taken + 3'd1;
  assign point_inc = {state_i.point[14:0], byte_i[5:0]};
  assign supp_off  = point_inc - SUPPLEMENT_BASE;

  always_comb begin
    st      = state_i;
    raw0    = REPLACEMENT_UNIT;
    raw1    = REPLACEMENT_UNIT;
    cnt     = 2'd0;
    as_lead = 1'b1;

    // Continue or break the open sequence
    if (state_i.exp_len != SEQ_NONE) begin
      if (is_cont) begin
        as_lead  = 1'b0;
        st.point = point_inc;
        st.taken = taken_inc;
        if (taken_inc >= state_i.exp_len) begin
          st = '{exp_len: SEQ_NONE, taken: 3'd0, point: 21'd0};
          if (point_inc > MAX_CODE_POINT) begin
            cnt = 2'd1;
          end else if (point_inc < SUPPLEMENT_BASE) begin
            raw0 = point_inc[15:0];
            cnt  = 2'd1;
          end else begin
            raw0 = {HIGH_SURR_TAG, supp_off[19:10]};
            raw1 = {LOW_SURR_TAG, supp_off[9:0]};
            cnt  = 2'd2;
          end
        end
      end else begin
        st  = '{exp_len: SEQ_NONE, taken: 3'd0, point: 21'd0};
        cnt = 2'd1;
      end
    end

    // Lead byte: emit ASCII or replacement, or open a sequence
    if (as_lead) begin
      if (byte_i[7] == 1'b0) begin
        if (cnt == 2'd0) raw0 = {8'd0, byte_i};
        else             raw1 = {8'd0, byte_i};
        cnt = cnt + 2'd1;
      end else if (byte_i[7:5] == 3'b110) begin
        st = '{exp_len: SEQ_LEN2, taken: 3'd1, point: {16'd0, byte_i[4:0]}};
      end else if (byte_i[7:4] == 4'b1110) begin
        st = '{exp_len: SEQ_LEN3, taken: 3'd1, point: {17'd0, byte_i[3:0]}};
      end else if (byte_i[7:3] == 5'b11110) begin
        st = '{exp_len: SEQ_LEN4, taken: 3'd1, point: {18'd0, byte_i[2:0]}};
      end else begin
        cnt = cnt + 2'd1;  // both slots already hold the replacement unit
      end
    end

    // Flush a sequence left open at end of stream
    if (eos_i && (st.exp_len != SEQ_NONE)) begin
      st  = '{exp_len: SEQ_NONE, taken: 3'd0, point: 21'd0};
      cnt = cnt + 2'd1;
    end
  end

  assign state_o     = st;
  assign res_o.count = cnt;
  assign res_o.unit0 = big_endian_i ? {raw0[7:0], raw0[15:8]} : raw0;
  assign res_o.unit1 = big_endian_i ? {raw1[7:0], raw1[15:8]} : raw1;

endmodule

// File: src/u8u16_outbuf.sv
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Two-entry result register; holds the code units of one byte and drains
// them one per cycle while out_tready is high.
// ----------------------------------------------------------------------------
module u8u16_outbuf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load_i,
  input  u8u16_pkg::dec_result_t  res_i,
  output logic                    free_o,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata,   // [15:0] code_unit
  output logic                    out_tlast    // last_in_run
);
  import u8u16_pkg::*;

  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic [15:0] head_r;
  logic [15:0] head_nxt;
  logic [15:0] tail_r;
  logic [15:0] tail_nxt;

  assign free_o = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (load_i) begin
      cnt_nxt  = res_i.count;
      head_nxt = res_i.unit0;
      tail_nxt = res_i.unit1;
    end else if (out_tvalid && out_tready) begin
      // advance the second unit to the head
      cnt_nxt  = cnt_r - 2'd1;
      head_nxt = tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = head_r;
  // units of one byte are loaded together, so the head is last when alone
  assign out_tlast  = (cnt_r == 2'd1);

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_i |-> ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready)))
    else $error("result loaded over undelivered units");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_i && (res_i.count == 2'd2)) |=> (out_tvalid && !out_tlast))
    else $error("first unit of a pair flagged last");

  a_pair_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd2) && out_tready) |=> (cnt_r == 2'd1))
    else $error("second unit of a pair lost");

endmodule

// File: src/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units out, byte order set by cfg.
// ----------------------------------------------------------------------------
// channel | direction | tdata / data       | side fields
// in_     | slave     | [7:0] data_byte    | tlast = end_of_stream
// out_    | master    | [15:0] code_unit   | tlast = last_in_run
// cfg_    | write     | [0] big_endian_out | -
//
// A byte is registered on accept and decoded from that register into the result
// register; bytes enter one per cycle while the result register has room. A byte
// that yields a surrogate pair holds the result register until both units drain.
// in_tready follows out_tready through the result register occupancy.
// Reset (synchronous, active low) clears the open sequence, the byte order
// and both valid stages.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] code_unit
  output logic        out_tlast,   // last_in_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data     // [0] big_endian_out
);
  import u8u16_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_eos_r;
  logic        big_endian_r;
  seq_state_t  seq_r;
  seq_state_t  seq_nxt;
  dec_result_t dec_res;
  logic        buf_free;
  logic        consume;
  logic        in_fire;

  assign cfg_ready = 1'b1;

  u8u16_decode u_decode (
    .byte_i       (s1_byte_r),
    .eos_i        (s1_eos_r),
    .big_endian_i (big_endian_r),
    .state_i      (seq_r),
    .state_o      (seq_nxt),
    .res_o        (dec_res)
  );

  // a byte with no result needs no room in the result register
  assign consume   = s1_valid_r && ((dec_res.count == 2'd0) || buf_free);
  assign in_tready = !s1_valid_r || consume;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_fire ? 1'b1 : (consume ? 1'b0 : s1_valid_r);

  u8u16_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (consume && (dec_res.count != 2'd0)),
    .res_i      (dec_res),
    .free_o     (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      big_endian_r <= 1'b0;
      seq_r        <= '{exp_len: SEQ_NONE, taken: 3'd0, point: 21'd0};
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_valid) begin
        big_endian_r <= cfg_data[0];
      end
      if (consume) begin
        seq_r <= seq_nxt;
      end
    end
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_eos_r  <= in_tlast;
    end
  end

  a_seq_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.exp_len == SEQ_NONE) || (seq_r.taken < seq_r.exp_len))
    else $error("open sequence already complete");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r.exp_len == SEQ_NONE) |-> ((seq_r.taken == 3'd0) && (seq_r.point == 21'd0)))
    else $error("closed sequence left partial state");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !consume) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("stalled byte lost");

endmodule
